// ===== hdl/wpm_pkg.sv =====
// Package: opcodes, wildcard symbols and the control bundle shared by the match cells.
package wpm_pkg;

    localparam int unsigned SYM_W = 8;
    localparam int unsigned LEN_W = 6;
    localparam int unsigned ROW_W = 64;

    localparam logic [SYM_W-1:0] STAR_SYM = 8'h2A;
    localparam logic [SYM_W-1:0] ANY_SYM  = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_TEXT   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic             clr;
        logic             load;
        logic             step;
        logic             wr;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
    } t_cell_ctl;

endpackage

// ===== hdl/wpm_if.sv =====
// Interfaces: request channel and result channel with valid/ready handshake.
interface wpm_req_if;
    logic                            valid;
    logic                            ready;
    wpm_pkg::t_opcode                opcode;
    logic [wpm_pkg::SYM_W-1:0]       symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface wpm_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            matched;
    logic                            pattern_full;
    logic [wpm_pkg::LEN_W-1:0]       pattern_size;

    modport source (output valid, output matched, output pattern_full, output pattern_size,
                    input ready);
    modport sink   (input valid, input matched, input pattern_full, input pattern_size,
                    output ready);
endinterface

// ===== hdl/wildcard_pattern_match.sv =====
// Top level: glob matcher built as a chain of pattern cells, one per pattern position.
// The result of an accepted request is captured in the output register.
// Throughput: one request per cycle while the result channel is ready; the row update is one pass over the cell chain.
// Reset: synchronous active low; empty pattern, row holds only the empty-prefix bit.
// The pattern store clears at reset, no clearing pass is needed.
module wildcard_pattern_match #(
    parameter int unsigned PATTERN_MAX = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wpm_req_if.sink     i_req,
    wpm_rsp_if.source   o_rsp
);

    localparam logic [wpm_pkg::LEN_W-1:0] MAX_L = wpm_pkg::LEN_W'(PATTERN_MAX);

    logic                      r_out_valid;
    logic                      r_matched;
    logic                      r_full;
    logic [wpm_pkg::LEN_W-1:0] r_size;

    logic [wpm_pkg::LEN_W-1:0] r_len;
    logic [wpm_pkg::LEN_W-1:0] n_len;
    logic                      r_last_star;
    logic                      n_last_star;
    logic                      r_bit0;
    logic                      n_bit0;
    logic                      n_full;

    logic                      w_accept;
    logic                      w_fold;
    logic                      w_store_full;
    wpm_pkg::t_cell_ctl        w_ctl;

    logic [PATTERN_MAX-1:0]    w_lit;
    logic [PATTERN_MAX-1:0]    w_next;
    logic [PATTERN_MAX-1:0]    w_bit;
    logic [wpm_pkg::ROW_W-1:0] w_row;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_fold       = (i_req.symbol == wpm_pkg::STAR_SYM) && r_last_star;
    assign w_store_full = (r_len >= MAX_L);

    always_comb begin
        w_ctl       = '0;
        w_ctl.len   = r_len;
        w_ctl.sym   = i_req.symbol;
        n_len       = r_len;
        n_last_star = r_last_star;
        n_bit0      = r_bit0;
        n_full      = 1'b0;
        if (w_accept) begin
            case (i_req.opcode)
                wpm_pkg::OP_CLEAR: begin
                    w_ctl.clr   = 1'b1;
                    n_len       = '0;
                    n_last_star = 1'b0;
                    n_bit0      = 1'b1;
                end
                wpm_pkg::OP_APPEND: begin
                    if (!w_fold) begin
                        if (w_store_full) begin
                            n_full = 1'b1;
                        end else begin
                            w_ctl.wr    = 1'b1;
                            n_len       = r_len + 1'b1;
                            n_last_star = (i_req.symbol == wpm_pkg::STAR_SYM);
                        end
                    end
                end
                wpm_pkg::OP_BEGIN: begin
                    w_ctl.load = 1'b1;
                    n_bit0     = 1'b1;
                end
                wpm_pkg::OP_TEXT: begin
                    w_ctl.step = 1'b1;
                    n_bit0     = 1'b0;
                end
                default: begin
                    n_bit0 = r_bit0;
                end
            endcase
        end
    end

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            if (k == 0) begin : g_first
                wpm_cell #(.IDX(k)) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctl       (w_ctl),
                    .i_lit_left  (1'b0),
                    .i_prev_left (r_bit0),
                    .o_lit       (w_lit[k]),
                    .o_next      (w_next[k]),
                    .o_bit       (w_bit[k])
                );
            end else begin : g_rest
                wpm_cell #(.IDX(k)) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctl       (w_ctl),
                    .i_lit_left  (w_lit[k-1]),
                    .i_prev_left (w_bit[k-1]),
                    .o_lit       (w_lit[k]),
                    .o_next      (w_next[k]),
                    .o_bit       (w_bit[k])
                );
            end
        end
    endgenerate

    always_comb begin
        w_row                  = '0;
        w_row[0]               = n_bit0;
        w_row[PATTERN_MAX:1]   = w_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_last_star <= 1'b0;
            r_bit0      <= 1'b1;
        end else begin
            r_len       <= n_len;
            r_last_star <= n_last_star;
            r_bit0      <= n_bit0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_out_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_matched <= w_row[n_len];
            r_full    <= n_full;
            r_size    <= n_len;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.matched      = r_matched;
    assign o_rsp.pattern_full = r_full;
    assign o_rsp.pattern_size = r_size;

endmodule

// ===== hdl/wpm_cell.sv =====
// Match cell: one pattern symbol and its prefix-match row bit.
module wpm_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wpm_pkg::t_cell_ctl        i_ctl,
    input  logic                      i_lit_left,
    input  logic                      i_prev_left,
    output logic                      o_lit,
    output logic                      o_next,
    output logic                      o_bit
);

    localparam logic [wpm_pkg::LEN_W-1:0] IDX_L = wpm_pkg::LEN_W'(IDX);

    logic [wpm_pkg::SYM_W-1:0] r_sym;
    logic                      r_bit;
    logic                      n_bit;
    logic                      w_active;
    logic                      w_star;
    logic                      w_hit;

    assign w_active = (IDX_L < i_ctl.len);
    assign w_star   = (r_sym == wpm_pkg::STAR_SYM);
    assign w_hit    = (r_sym == wpm_pkg::ANY_SYM) || (r_sym == i_ctl.sym);
    assign o_lit    = w_hit & i_prev_left;
    assign o_next   = n_bit;
    assign o_bit    = r_bit;

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.clr) begin
            n_bit = 1'b0;
        end else if (i_ctl.load) begin
            n_bit = (IDX == 0) && w_active && w_star;
        end else if (i_ctl.step) begin
            n_bit = w_active && (w_star ? (r_bit | i_lit_left) : (w_hit & i_prev_left));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= '0;
        end else if (i_ctl.wr && (i_ctl.len == IDX_L)) begin
            r_sym <= i_ctl.sym;
        end
    end

endmodule
